/* rtl/sha1v_pkg.sv */
`default_nettype none
package sha1v_pkg;

    localparam logic [1:0] CMD_ABSORB = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_AFTER    = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    // Datapath commands issued by the controller.
    typedef enum logic [2:0] {
        DP_NOP,
        DP_START,
        DP_WRITE,
        DP_ROUND,
        DP_CLEAR,
        DP_FOLD,
        DP_RESET
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [5:0] addr;
        logic [7:0] wdata;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
    } dp_stat_t;

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        begin
            unique case (t)
                7'd0: k = 32'h428a2f98; 7'd1: k = 32'h71374491;
                7'd2: k = 32'hb5c0fbcf; 7'd3: k = 32'he9b5dba5;
                7'd4: k = 32'h3956c25b; 7'd5: k = 32'h59f111f1;
                7'd6: k = 32'h923f82a4; 7'd7: k = 32'hab1c5ed5;
                7'd8: k = 32'hd807aa98; 7'd9: k = 32'h12835b01;
                7'd10: k = 32'h243185be; 7'd11: k = 32'h550c7dc3;
                7'd12: k = 32'h72be5d74; 7'd13: k = 32'h80deb1fe;
                7'd14: k = 32'h9bdc06a7; 7'd15: k = 32'hc19bf174;
                7'd16: k = 32'he49b69c1; 7'd17: k = 32'hefbe4786;
                7'd18: k = 32'h0fc19dc6; 7'd19: k = 32'h240ca1cc;
                7'd20: k = 32'h2de92c6f; 7'd21: k = 32'h4a7484aa;
                7'd22: k = 32'h5cb0a9dc; 7'd23: k = 32'h76f988da;
                7'd24: k = 32'h983e5152; 7'd25: k = 32'ha831c66d;
                7'd26: k = 32'hb00327c8; 7'd27: k = 32'hbf597fc7;
                7'd28: k = 32'hc6e00bf3; 7'd29: k = 32'hd5a79147;
                7'd30: k = 32'h06ca6351; 7'd31: k = 32'h14292967;
                7'd32: k = 32'h27b70a85; 7'd33: k = 32'h2e1b2138;
                7'd34: k = 32'h4d2c6dfc; 7'd35: k = 32'h53380d13;
                7'd36: k = 32'h650a7354; 7'd37: k = 32'h766a0abb;
                7'd38: k = 32'h81c2c92e; 7'd39: k = 32'h92722c85;
                7'd40: k = 32'ha2bfe8a1; 7'd41: k = 32'ha81a664b;
                7'd42: k = 32'hc24b8b70; 7'd43: k = 32'hc76c51a3;
                7'd44: k = 32'hd192e819; 7'd45: k = 32'hd6990624;
                7'd46: k = 32'hf40e3585; 7'd47: k = 32'h106aa070;
                7'd48: k = 32'h19a4c116; 7'd49: k = 32'h1e376c08;
                7'd50: k = 32'h2748774c; 7'd51: k = 32'h34b0bcb5;
                7'd52: k = 32'h391c0cb3; 7'd53: k = 32'h4ed8aa4a;
                7'd54: k = 32'h5b9cca4f; 7'd55: k = 32'h682e6ff3;
                7'd56: k = 32'h748f82ee; 7'd57: k = 32'h78a5636f;
                7'd58: k = 32'h84c87814; 7'd59: k = 32'h8cc70208;
                7'd60: k = 32'h90befffa; 7'd61: k = 32'ha4506ceb;
                7'd62: k = 32'hbef9a3f7; 7'd63: k = 32'hc67178f2;
                7'd64: k = 32'hca273ece; 7'd65: k = 32'hd186b8c7;
                7'd66: k = 32'heada7dd6; 7'd67: k = 32'hf57d4f7f;
                7'd68: k = 32'h06f067aa; 7'd69: k = 32'h0a637dc5;
                7'd70: k = 32'h113f9804; 7'd71: k = 32'h1b710b35;
                7'd72: k = 32'h28db77f5; 7'd73: k = 32'h32caab7b;
                7'd74: k = 32'h3c9ebe0a; 7'd75: k = 32'h431d67c4;
                7'd76: k = 32'h4cc5d4be; 7'd77: k = 32'h597f299c;
                7'd78: k = 32'h5fcb6fab; 7'd79: k = 32'h6c44198c;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/sha1v_datapath.sv */
`default_nettype none
// Block buffer held as a 16-word schedule shift register plus the round
// unit and the chaining words. Bytes are written in big-endian order.
module sha1v_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sha1v_pkg::dp_cmd_t  cmd,
    output sha1v_pkg::dp_stat_t      stat,
    input  wire logic [2:0]          hsel,
    output logic [31:0]              hword
);
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  t_reg;
    logic        busy_reg;
    logic [31:0] f, tmp, wnew;

    assign stat.busy = busy_reg;

    always_comb begin
        if (t_reg < 7'd20) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
        end else if (t_reg < 7'd40 || t_reg >= 7'd60) begin
            f = b_reg ^ c_reg ^ d_reg;
        end else begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
        end
        tmp  = {a_reg[26:0], a_reg[31:27]} + f + e_reg + w_reg[0]
             + sha1v_pkg::round_k(t_reg);
        wnew = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        for (int i = 0; i < 16; i++) begin
            w_next[i] = w_reg[i];
        end
        unique case (cmd.op)
            sha1v_pkg::DP_WRITE: begin
                // Byte at address p lands in word p/4, lane 3-p%4.
                w_next[cmd.addr[5:2]][(5'd24 - {cmd.addr[1:0], 3'b000}) +: 8] =
                    cmd.wdata;
            end
            sha1v_pkg::DP_CLEAR: begin
                for (int i = 0; i < 16; i++) begin
                    w_next[i] = '0;
                end
            end
            sha1v_pkg::DP_NOP, sha1v_pkg::DP_START, sha1v_pkg::DP_ROUND,
            sha1v_pkg::DP_FOLD, sha1v_pkg::DP_RESET: begin
            end
            default: begin
            end
        endcase
        if (busy_reg) begin
            for (int i = 0; i < 15; i++) begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = {wnew[30:0], wnew[31]};
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            w_reg[i] <= w_next[i];
        end
        if (!aresetn || cmd.op == sha1v_pkg::DP_RESET) begin
            h_reg[0] <= sha1v_pkg::H0_INIT;
            h_reg[1] <= sha1v_pkg::H1_INIT;
            h_reg[2] <= sha1v_pkg::H2_INIT;
            h_reg[3] <= sha1v_pkg::H3_INIT;
            h_reg[4] <= sha1v_pkg::H4_INIT;
            busy_reg <= 1'b0;
            t_reg    <= '0;
        end else if (cmd.op == sha1v_pkg::DP_START) begin
            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
            d_reg <= h_reg[3]; e_reg <= h_reg[4];
            t_reg    <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            a_reg <= tmp; b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg; e_reg <= d_reg;
            t_reg <= t_reg + 7'd1;
            if (t_reg == 7'd79) begin
                busy_reg <= 1'b0;
            end
        end else if (cmd.op == sha1v_pkg::DP_FOLD) begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    always_comb begin
        unique case (hsel)
            3'd0: hword = h_reg[0];
            3'd1: hword = h_reg[1];
            3'd2: hword = h_reg[2];
            3'd3: hword = h_reg[3];
            default: hword = h_reg[4];
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && t_reg != 7'd79 |=> busy_reg)
        else $error("round unit stopped early");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> t_reg <= 7'd79)
        else $error("round counter out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && t_reg == 7'd79 |=> !busy_reg)
        else $error("round unit overran");
endmodule
`default_nettype wire

/* rtl/sha1v_ctrl.sv */
`default_nettype none
module sha1v_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_command,
    input  wire logic [7:0]          s_data_byte,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [31:0]              m_digest_word,
    output logic [2:0]               m_word_index,
    output logic [1:0]               m_status,
    output logic                     m_last_result,
    output sha1v_pkg::dp_cmd_t       cmd,
    input  wire sha1v_pkg::dp_stat_t stat,
    output logic [2:0]               hsel,
    input  wire logic [31:0]         hword
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CMP    = 4'd1;
    localparam logic [3:0] S_FOLD   = 4'd2;
    localparam logic [3:0] S_PAD    = 4'd3;
    localparam logic [3:0] S_ZERO   = 4'd4;
    localparam logic [3:0] S_LEN    = 4'd5;
    localparam logic [3:0] S_EMIT   = 4'd6;
    localparam logic [3:0] S_ERR    = 4'd7;
    localparam logic [3:0] S_WAIT   = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic        fin_reg, fin_next;
    logic [1:0]  err_reg, err_next;
    logic        pad_reg, pad_next;   // last compression of the finish
    logic [2:0]  idx_reg, idx_next;
    logic [3:0]  ret_reg, ret_next;   // state after a compression
    logic [63:0] len_inc;
    logic        acc;

    assign s_ready = (state_reg == S_IDLE);
    assign acc     = s_valid && s_ready;
    assign len_inc = len_reg + 64'd8;
    assign hsel    = idx_reg;
    assign m_valid = (state_reg == S_EMIT) || (state_reg == S_ERR);
    assign m_digest_word = (state_reg == S_EMIT) ? hword : 32'd0;
    assign m_word_index  = (state_reg == S_EMIT) ? idx_reg : 3'd0;
    assign m_status      = (state_reg == S_EMIT) ? sha1v_pkg::ST_OK : err_reg;
    assign m_last_result = (state_reg == S_ERR) || idx_reg == 3'd4;

    always_comb begin
        state_next = state_reg;
        pos_next = pos_reg; len_next = len_reg; fin_next = fin_reg;
        err_next = err_reg; pad_next = pad_reg; idx_next = idx_reg;
        ret_next = ret_reg;
        cmd.op = sha1v_pkg::DP_NOP; cmd.addr = pos_reg; cmd.wdata = 8'd0;
        unique case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    priority if (s_command == sha1v_pkg::CMD_ABSORB) begin
                        if (fin_reg) begin
                            err_next = sha1v_pkg::ST_AFTER;
                            state_next = S_ERR;
                        end else if (err_reg == sha1v_pkg::ST_OK) begin
                            cmd.op = sha1v_pkg::DP_WRITE;
                            cmd.wdata = s_data_byte;
                            pos_next = pos_reg + 6'd1;
                            len_next = len_inc;
                            if (len_inc == 64'd0) begin
                                err_next = sha1v_pkg::ST_TOO_LONG;
                            end
                            if (pos_reg == 6'd63) begin
                                ret_next = S_IDLE;
                                state_next = S_CMP;
                            end
                        end
                    end else if (s_command == sha1v_pkg::CMD_FINISH) begin
                        idx_next = 3'd0;
                        if (err_reg != sha1v_pkg::ST_OK) begin
                            state_next = S_ERR;
                        end else if (fin_reg) begin
                            state_next = S_EMIT;
                        end else begin
                            state_next = S_PAD;
                        end
                    end else if (s_command == sha1v_pkg::CMD_START) begin
                        cmd.op = sha1v_pkg::DP_RESET;
                        pos_next = '0; len_next = '0; fin_next = 1'b0;
                        err_next = sha1v_pkg::ST_OK;
                    end else begin
                    end
                end
            end
            S_PAD: begin
                cmd.op = sha1v_pkg::DP_WRITE;
                cmd.wdata = sha1v_pkg::PAD_BYTE;
                pos_next = pos_reg + 6'd1;
                if (pos_reg == 6'd63) begin
                    ret_next = S_ZERO;
                    state_next = S_CMP;
                end else begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO: begin
                // Zero fill to the length field, or to block end if past it.
                if (pos_reg == sha1v_pkg::LEN_POS) begin
                    state_next = S_LEN;
                end else begin
                    cmd.op = sha1v_pkg::DP_WRITE;
                    pos_next = pos_reg + 6'd1;
                    if (pos_reg == 6'd63) begin
                        ret_next = S_ZERO;
                        state_next = S_CMP;
                    end
                end
            end
            S_LEN: begin
                cmd.op = sha1v_pkg::DP_WRITE;
                cmd.wdata = len_reg[(6'd56 - {pos_reg[2:0], 3'b000}) +: 8];
                pos_next = pos_reg + 6'd1;
                if (pos_reg == 6'd63) begin
                    ret_next = S_EMIT;
                    pad_next = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                cmd.op = sha1v_pkg::DP_START;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (!stat.busy) begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                cmd.op = sha1v_pkg::DP_FOLD;
                pos_next = '0;
                state_next = ret_reg;
                if (pad_reg) begin
                    pad_next = 1'b0;
                    len_next = '0;
                    fin_next = 1'b1;
                    idx_next = 3'd0;
                end
            end
            S_EMIT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd4) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; pos_reg <= '0; len_reg <= '0;
            fin_reg <= 1'b0; err_reg <= sha1v_pkg::ST_OK; pad_reg <= 1'b0;
            idx_reg <= '0; ret_reg <= S_IDLE;
        end else begin
            state_reg <= state_next; pos_reg <= pos_next; len_reg <= len_next;
            fin_reg <= fin_next; err_reg <= err_next; pad_reg <= pad_next;
            idx_reg <= idx_next; ret_reg <= ret_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> err_reg == sha1v_pkg::ST_OK && fin_reg)
        else $error("digest emitted without a finished message");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WAIT |-> stat.busy || $past(state_reg) == S_WAIT)
        else $error("compression not started");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ERR |-> err_reg != sha1v_pkg::ST_OK)
        else $error("error transfer without an error code");
endmodule
`default_nettype wire

/* rtl/sha1_variant_hash_80_constants.sv */
`default_nettype none
// SHA-1 style hash whose round t adds its own constant from an 80-word table.
// Send one message byte per transfer with command 0; command 1 pads the
// message and returns the five digest words as five result transfers, word 0
// first, the last marked by m_last_result; command 2 starts a new message.
// Errors (a byte after finish, or a message of 2^64 bits or more) give one
// result transfer with a non-zero status. s_ready stays high between bytes,
// except after the 64th of each block, when it stays low while the controller
// starts the shared round unit, runs its 80 rounds, sees it stop and folds
// the result into the chaining words. Finish pads the message and runs one or
// two compressions before the first digest word appears; a repeated finish
// starts emitting on the next cycle. There is no clearing pass after reset.
module sha1_variant_hash_80_constants (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic [1:0]       m_status,
    output logic             m_last_result
);
    // Command and status between the sequencer and the datapath.
    sha1v_pkg::dp_cmd_t  cmd;
    sha1v_pkg::dp_stat_t stat;
    logic [2:0]          hsel;
    logic [31:0]         hword;

    sha1v_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .s_data_byte,
        .m_valid, .m_ready, .m_digest_word, .m_word_index, .m_status,
        .m_last_result, .cmd, .stat, .hsel, .hword
    );

    sha1v_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat, .hsel, .hword
    );
endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none

// Self-checking bench for the SHA-1 style hash with 80 round constants.
// Stimulus goes in as byte, finish, start and spare-command transfers on the input channel.
// Every accepted transfer is run through a digest predictor held in this
// module. The predictor queues the result transfers it expects, and a
// checker compares each accepted result transfer with the oldest of them.
module tb_top;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // The high halves of the SHA-512 constants, one per round.
    localparam logic [31:0] ROUND_CONST [80] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2, 32'hca273ece,
        32'hd186b8c7, 32'heada7dd6, 32'hf57d4f7f, 32'h06f067aa, 32'h0a637dc5,
        32'h113f9804, 32'h1b710b35, 32'h28db77f5, 32'h32caab7b, 32'h3c9ebe0a,
        32'h431d67c4, 32'h4cc5d4be, 32'h597f299c, 32'h5fcb6fab, 32'h6c44198c
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic [1:0]  status;
        logic        last;
    } digest_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic [1:0]  m_status;
    logic        m_last_result;

    // Predictor state: the chaining words, the partly filled block, the
    // count of bytes in it, the message length in bits and the sticky flags.
    logic [31:0] chain_words [5];
    logic [7:0]  msg_block [64];
    int unsigned block_fill;
    logic [63:0] msg_bits;
    logic        digest_done;
    logic [1:0]  sticky_status;

    digest_beat_t pending_beats [$];
    int unsigned  error_count;
    int unsigned  items_sent;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    int unsigned  recv_hold_cycles;

    sha1_variant_hash_80_constants i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_status      (m_status),
        .m_last_result (m_last_result)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // One 80-round compression of the buffered block into the chaining words.
    function automatic void compress_msg_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        for (int i = 16; i < 80; i++) begin
            w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
            end else if (i < 40 || i >= 60) begin
                f = b ^ c ^ d;
            end else begin
                f = (b & c) | (b & d) | (c & d);
            end
            t = rol32(a, 5) + f + e + w[i] + ROUND_CONST[i];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
        chain_words[4] += e;
        block_fill = 0;
    endfunction

    function automatic void restart_digest();
        chain_words[0] = sha1v_pkg::H0_INIT;
        chain_words[1] = sha1v_pkg::H1_INIT;
        chain_words[2] = sha1v_pkg::H2_INIT;
        chain_words[3] = sha1v_pkg::H3_INIT;
        chain_words[4] = sha1v_pkg::H4_INIT;
        foreach (msg_block[i]) msg_block[i] = 8'h00;
        block_fill    = 0;
        msg_bits      = 64'd0;
        digest_done   = 1'b0;
        sticky_status = sha1v_pkg::ST_OK;
    endfunction

    function automatic void queue_error_beat(input logic [1:0] code);
        digest_beat_t beat;
        beat = '{word: 32'd0, index: 3'd0, status: code, last: 1'b1};
        pending_beats.push_back(beat);
    endfunction

    // Standard padding: the marker byte, zeros, then the big-endian bit
    // length; a second block is needed when the marker lands past byte 55.
    function automatic void pad_final_blocks();
        int unsigned p;
        p = block_fill;
        msg_block[p] = sha1v_pkg::PAD_BYTE;
        p++;
        if (p > sha1v_pkg::LEN_POS) begin
            while (p < 64) begin
                msg_block[p] = 8'h00;
                p++;
            end
            compress_msg_block();
            p = 0;
        end
        while (p < sha1v_pkg::LEN_POS) begin
            msg_block[p] = 8'h00;
            p++;
        end
        for (int i = 0; i < 8; i++) begin
            msg_block[sha1v_pkg::LEN_POS + i] = msg_bits[63 - 8*i -: 8];
        end
        compress_msg_block();
    endfunction

    // Works out what one accepted transfer does and queues its results.
    function automatic void predict_digest(input logic [1:0] cmd, input logic [7:0] data);
        digest_beat_t beat;
        case (cmd)
            sha1v_pkg::CMD_ABSORB: begin
                if (digest_done) begin
                    sticky_status = sha1v_pkg::ST_AFTER;
                    queue_error_beat(sha1v_pkg::ST_AFTER);
                end else if (sticky_status == sha1v_pkg::ST_OK) begin
                    msg_block[block_fill] = data;
                    block_fill++;
                    msg_bits += 64'd8;
                    if (msg_bits == 64'd0) begin
                        sticky_status = sha1v_pkg::ST_TOO_LONG;
                    end
                    if (block_fill == 64) begin
                        compress_msg_block();
                    end
                end
            end
            sha1v_pkg::CMD_FINISH: begin
                if (sticky_status != sha1v_pkg::ST_OK) begin
                    queue_error_beat(sticky_status);
                end else begin
                    if (!digest_done) begin
                        pad_final_blocks();
                        foreach (msg_block[i]) msg_block[i] = 8'h00;
                        msg_bits    = 64'd0;
                        digest_done = 1'b1;
                    end
                    for (int k = 0; k < 5; k++) begin
                        beat = '{word: chain_words[k], index: 3'(k),
                                 status: sha1v_pkg::ST_OK, last: (k == 4)};
                        pending_beats.push_back(beat);
                    end
                end
            end
            sha1v_pkg::CMD_START: begin
                restart_digest();
            end
            default: begin
                // The spare command code is ignored by the block.
            end
        endcase
    endfunction

    // Offers one transfer, idling first at the current source rate, and
    // predicts it at the edge where it is accepted. Valid is left high so
    // that back-to-back transfers never drop it within one time step.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_command   = cmd;
        s_data_byte = data;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_digest(cmd, data);
        if (cmd != CMD_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic go_quiet();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // A well-formed message with random content and an occasional spare command
    // before a byte, sometimes followed by a repeated finish or a stray byte after finish.
    task automatic send_message(input int unsigned len);
        send_item(sha1v_pkg::CMD_START, 8'($urandom));
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) begin
                send_item(CMD_UNUSED, 8'($urandom));
            end
            send_item(sha1v_pkg::CMD_ABSORB, 8'($urandom));
        end
        send_item(sha1v_pkg::CMD_FINISH, 8'($urandom));
        if ($urandom_range(3) == 0) begin
            send_item(sha1v_pkg::CMD_FINISH, 8'($urandom));
        end
        if ($urandom_range(5) == 0) begin
            send_item(sha1v_pkg::CMD_ABSORB, 8'($urandom));
            send_item(sha1v_pkg::CMD_FINISH, 8'($urandom));
        end
    endtask

    // Lengths cluster at the padding boundaries, otherwise stay short.
    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 55;
            1: return 56;
            2: return 63 + $urandom_range(1);
            3: return 119 + $urandom_range(1);
            default: return $urandom_range(20);
        endcase
    endfunction

    task automatic drain_results();
        while (pending_beats.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Empty message, field extremes, repeated finish, the byte-after-finish error,
    // the spare command code and a restart.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(sha1v_pkg::CMD_FINISH, 8'h00);
        send_item(sha1v_pkg::CMD_FINISH, 8'hFF);
        send_item(sha1v_pkg::CMD_START, 8'h00);
        send_item(sha1v_pkg::CMD_ABSORB, 8'h00);
        send_item(sha1v_pkg::CMD_ABSORB, 8'hFF);
        send_item(CMD_UNUSED, 8'hA5);
        send_item(sha1v_pkg::CMD_ABSORB, 8'h80);
        send_item(sha1v_pkg::CMD_FINISH, 8'h00);
        send_item(sha1v_pkg::CMD_ABSORB, 8'h5A);
        send_item(sha1v_pkg::CMD_FINISH, 8'h00);
        send_item(sha1v_pkg::CMD_ABSORB, 8'h01);
        send_item(sha1v_pkg::CMD_START, 8'hFF);
        send_item(sha1v_pkg::CMD_ABSORB, 8'h7F);
        send_item(sha1v_pkg::CMD_FINISH, 8'h00);
        go_quiet();
        drain_results();
    endtask

    task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                               input int unsigned target);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (items_sent < target) begin
            send_message(pick_length());
        end
        go_quiet();
        drain_results();
    endtask

    // The receiver holds off for a long stretch while finishes keep coming,
    // so the result side backs up into the input.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        recv_hold_cycles = 600;
        send_item(sha1v_pkg::CMD_START, 8'h00);
        send_item(sha1v_pkg::CMD_ABSORB, 8'h3C);
        for (int i = 0; i < 6; i++) begin
            send_item(sha1v_pkg::CMD_FINISH, 8'h00);
        end
        send_item(sha1v_pkg::CMD_ABSORB, 8'hC3);
        send_item(sha1v_pkg::CMD_FINISH, 8'h00);
        go_quiet();
        drain_results();
    endtask

    // The receiver changes ready at the falling edge, either counting down a
    // hold-off or stalling at random at the current rate.
    always @(negedge aclk) begin
        if (recv_hold_cycles > 0) begin
            m_ready = 1'b0;
            recv_hold_cycles--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        digest_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result transfer word %h index %0d status %0d",
                         $time, m_digest_word, m_word_index, m_status);
            end else begin
                want = pending_beats.pop_front();
                if (m_digest_word !== want.word) begin
                    error_count++;
                    $display("%0t: digest word expected %h actual %h",
                             $time, want.word, m_digest_word);
                end
                if (m_word_index !== want.index) begin
                    error_count++;
                    $display("%0t: word index expected %0d actual %0d",
                             $time, want.index, m_word_index);
                end
                if (m_status !== want.status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_status);
                end
                if (m_last_result !== want.last) begin
                    error_count++;
                    $display("%0t: last flag expected %0d actual %0d",
                             $time, want.last, m_last_result);
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("sha1_variant_hash_80_constants: mismatch");
        $finish;
    end

    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_command        = sha1v_pkg::CMD_ABSORB;
        s_data_byte      = 8'h00;
        m_ready          = 1'b0;
        error_count      = 0;
        items_sent       = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 0;
        restart_digest();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random(0, 0, 70);
        test_random(82, 0, 120);
        test_random(0, 82, 170);
        test_random(38, 38, 220);
        test_backpressure();

        // Keep watching after the tests so that any stray result
        // transfer after the last expected one is caught.
        repeat (300) @(posedge aclk);
        if (error_count == 0 && pending_beats.size() == 0) begin
            $display("sha1_variant_hash_80_constants: match");
        end else begin
            $display("sha1_variant_hash_80_constants: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
